[rtl/core/wal_pkg.sv]
`timescale 1ns / 1ps

package wal_pkg;

    localparam int LOG_ENTRIES      = 30;
    localparam int OPERATION_BLOCKS = 10;
    localparam int BLOCK_BITS       = 20;

    localparam int IDX_W       = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(LOG_ENTRIES + 1);
    localparam int OPEN_W      = 3;
    localparam int OPEN_MAX    = 7;
    localparam int NEED_W      = $clog2(LOG_ENTRIES + (OPEN_MAX + 1) * OPERATION_BLOCKS + 1);
    localparam int START_W     = 20;
    localparam int SIZE_W      = 11;
    localparam int SIZE_CMP_W  = SIZE_W + 1;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 20;
    localparam int BLK_FIELD_W = 20;
    localparam int ECNT_W      = 5;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (3 + 2 + 2 * BLK_FIELD_W + ECNT_W + 2);

    typedef enum logic [1:0] {
        OP_BEGIN  = 2'd0,
        OP_END    = 2'd1,
        OP_RECORD = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_WAIT     = 3'd1,
        ST_DONE     = 3'd2,
        ST_TOO_BIG  = 3'd3,
        ST_OUTSIDE  = 3'd4,
        ST_NO_BEGIN = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_COPY    = 2'd1,
        CMD_HEADER  = 2'd2,
        CMD_INSTALL = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_LOG_START = 2'd0,
        CFG_LOG_SIZE  = 2'd1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_RECFIN,
        S_COPY,
        S_HDR,
        S_INST,
        S_CLR
    } t_state;

    typedef struct packed {
        t_status                 status;
        t_cmd                    command;
        logic [BLK_FIELD_W-1:0]  source_block;
        logic [BLK_FIELD_W-1:0]  dest_block;
        logic [ECNT_W-1:0]       entry_count;
        logic                    pin_new;
        logic                    wake_waiters;
        logic                    last;
    } t_result;

    typedef struct packed {
        logic             rotate;
        logic             load;
        logic [IDX_W-1:0] load_idx;
    } t_chain_ctl;

endpackage

[rtl/core/wal_cell.sv]
`timescale 1ns / 1ps

module wal_cell (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic                          i_load,
    input  logic [wal_pkg::BLOCK_BITS-1:0] i_next,
    input  logic [wal_pkg::BLOCK_BITS-1:0] i_load_value,
    output logic [wal_pkg::BLOCK_BITS-1:0] o_value
);
    import wal_pkg::*;

    logic [BLOCK_BITS-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= i_load_value;
        end else if (i_shift) begin
            r_value <= i_next;
        end
    end

    assign o_value = r_value;

endmodule

[rtl/core/wal_chain.sv]
`timescale 1ns / 1ps

module wal_chain (
    input  logic                           i_clk,
    input  wal_pkg::t_chain_ctl            i_ctl,
    input  logic [wal_pkg::BLOCK_BITS-1:0] i_key,
    output logic [wal_pkg::BLOCK_BITS-1:0] o_head,
    output logic                           o_match
);
    import wal_pkg::*;

    logic [BLOCK_BITS-1:0] w_vals [LOG_ENTRIES];

    // Ring of cells: each cell takes its upper neighbour, the top one wraps to the head
    for (genvar g = 0; g < LOG_ENTRIES; g++) begin : g_cell
        wal_cell u_cell (
            .i_clk        (i_clk),
            .i_shift      (i_ctl.rotate),
            .i_load       (i_ctl.load && (i_ctl.load_idx == IDX_W'(g))),
            .i_next       (w_vals[(g + 1) % LOG_ENTRIES]),
            .i_load_value (i_key),
            .o_value      (w_vals[g])
        );
    end

    assign o_head  = w_vals[0];
    assign o_match = (w_vals[0] == i_key);

endmodule

[rtl/core/wal_ctrl.sv]
`timescale 1ns / 1ps

module wal_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  wal_pkg::t_op                   i_op,
    input  logic [wal_pkg::BLOCK_BITS-1:0] i_blk,
    input  logic [wal_pkg::START_W-1:0]    i_log_start,
    input  logic [wal_pkg::SIZE_W-1:0]     i_log_size,
    input  logic                           i_can_load,
    output logic                           o_res_valid,
    output wal_pkg::t_result               o_res,
    output wal_pkg::t_chain_ctl            o_chain,
    output logic [wal_pkg::BLOCK_BITS-1:0] o_key,
    input  logic [wal_pkg::BLOCK_BITS-1:0] i_head,
    input  logic                           i_match
);
    import wal_pkg::*;

    t_state                r_state, n_state;
    t_op                   r_op;
    logic [BLOCK_BITS-1:0] r_blk;
    logic [OPEN_W-1:0]     r_open, n_open;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_step, n_step;
    logic                  r_found, n_found;

    logic [NEED_W-1:0]     w_need;
    logic                  w_too_big;
    logic                  w_start_commit;
    logic                  w_start_search;
    logic                  w_in_list;
    logic                  w_last_step;
    logic                  w_adv;
    logic [BLOCK_BITS-1:0] w_log_blk;
    logic [IDX_W-1:0]      w_step_inc;

    assign w_need = NEED_W'(r_count)
                  + NEED_W'(NEED_W'(NEED_W'(r_open) + NEED_W'(1)) * NEED_W'(OPERATION_BLOCKS));
    assign w_too_big = (r_count >= CNT_W'(LOG_ENTRIES))
                    || (SIZE_CMP_W'(SIZE_CMP_W'(r_count) + SIZE_CMP_W'(1))
                        >= SIZE_CMP_W'(i_log_size));
    assign w_start_commit = (r_op == OP_END) && (r_open == OPEN_W'(1)) && (r_count != '0);
    assign w_start_search = (r_op == OP_RECORD) && !w_too_big && (r_open != '0);
    assign w_in_list   = (CNT_W'(r_step) < r_count);
    assign w_last_step = (r_step == IDX_W'(LOG_ENTRIES - 1));
    assign w_adv       = w_in_list ? i_can_load : 1'b1;
    assign w_step_inc  = w_last_step ? '0 : IDX_W'(r_step + IDX_W'(1));
    assign w_log_blk   = BLOCK_BITS'(BLOCK_BITS'(i_log_start) + BLOCK_BITS'(r_step)
                                     + BLOCK_BITS'(1));

    assign o_in_ready = (r_state == S_IDLE);
    assign o_key      = r_blk;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_op != OP_NONE)) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_start_commit)      n_state = S_COPY;
                else if (w_start_search) n_state = S_SEARCH;
                else if (i_can_load)     n_state = S_IDLE;
            end
            S_SEARCH: begin
                if (w_last_step) n_state = S_RECFIN;
            end
            S_RECFIN: begin
                if (i_can_load) n_state = S_IDLE;
            end
            S_COPY: begin
                if (w_adv && w_last_step) n_state = S_HDR;
            end
            S_HDR: begin
                if (i_can_load) n_state = S_INST;
            end
            S_INST: begin
                if (w_adv && w_last_step) n_state = S_CLR;
            end
            S_CLR: begin
                if (i_can_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.status  = ST_DONE;
        o_res.command = CMD_NONE;
        o_chain     = '0;
        n_open      = r_open;
        n_count     = r_count;
        n_step      = r_step;
        n_found     = r_found;
        unique case (r_state)
            S_IDLE: begin
            end
            S_EXEC: begin
                o_res.last = 1'b1;
                unique case (r_op)
                    OP_BEGIN: begin
                        o_res_valid = 1'b1;
                        if ((r_open == OPEN_W'(OPEN_MAX)) || (w_need > NEED_W'(LOG_ENTRIES))) begin
                            o_res.status = ST_WAIT;
                        end else begin
                            o_res.status = ST_GRANTED;
                            if (i_can_load) n_open = OPEN_W'(r_open + OPEN_W'(1));
                        end
                    end
                    OP_END: begin
                        if (r_open == '0) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_NO_BEGIN;
                        end else if (w_start_commit) begin
                            n_open = OPEN_W'(r_open - OPEN_W'(1));
                            n_step = '0;
                        end else begin
                            o_res_valid        = 1'b1;
                            o_res.wake_waiters = 1'b1;
                            if (i_can_load) n_open = OPEN_W'(r_open - OPEN_W'(1));
                        end
                    end
                    OP_RECORD: begin
                        if (w_too_big) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_TOO_BIG;
                        end else if (r_open == '0) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_OUTSIDE;
                        end else begin
                            n_step  = '0;
                            n_found = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SEARCH: begin
                // Full turn of the ring: order is back in place at the end
                o_chain.rotate = 1'b1;
                n_step         = w_step_inc;
                if (w_in_list && i_match) n_found = 1'b1;
            end
            S_RECFIN: begin
                o_res_valid   = 1'b1;
                o_res.last    = 1'b1;
                o_res.pin_new = !r_found;
                if (i_can_load && !r_found) begin
                    o_chain.load     = 1'b1;
                    o_chain.load_idx = IDX_W'(r_count);
                    n_count          = CNT_W'(r_count + CNT_W'(1));
                end
            end
            S_COPY: begin
                o_res_valid        = w_in_list;
                o_res.command      = CMD_COPY;
                o_res.source_block = BLK_FIELD_W'(i_head);
                o_res.dest_block   = BLK_FIELD_W'(w_log_blk);
                if (w_adv) begin
                    o_chain.rotate = 1'b1;
                    n_step         = w_step_inc;
                end
            end
            S_HDR: begin
                o_res_valid       = 1'b1;
                o_res.command     = CMD_HEADER;
                o_res.dest_block  = BLK_FIELD_W'(BLOCK_BITS'(i_log_start));
                o_res.entry_count = ECNT_W'(r_count);
            end
            S_INST: begin
                o_res_valid        = w_in_list;
                o_res.command      = CMD_INSTALL;
                o_res.source_block = BLK_FIELD_W'(w_log_blk);
                o_res.dest_block   = BLK_FIELD_W'(i_head);
                if (w_adv) begin
                    o_chain.rotate = 1'b1;
                    n_step         = w_step_inc;
                end
            end
            S_CLR: begin
                o_res_valid        = 1'b1;
                o_res.command      = CMD_HEADER;
                o_res.dest_block   = BLK_FIELD_W'(BLOCK_BITS'(i_log_start));
                o_res.wake_waiters = 1'b1;
                o_res.last         = 1'b1;
                if (i_can_load) n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_open  <= '0;
            r_count <= '0;
            r_step  <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_count <= n_count;
            r_step  <= n_step;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_op  <= i_op;
            r_blk <= i_blk;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(LOG_ENTRIES))
        else $error("entry count beyond table depth");

    a_rotate_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_chain.rotate |-> (r_state == S_SEARCH || r_state == S_COPY || r_state == S_INST))
        else $error("ring rotated outside a scan");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_op != OP_NONE) |=> (r_state == S_EXEC))
        else $error("accepted item not dispatched");

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR && i_can_load) |=> (r_count == '0 && r_state == S_IDLE))
        else $error("commit did not empty the log");

    a_search_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_open != '0))
        else $error("search with no open operation");

endmodule

[rtl/core/write_ahead_log_manager.sv]
`timescale 1ns / 1ps
// Begin, end and error results are registered from the execute state once the output can take them.
// A record scans the full ring of 30 cells, one cell a cycle, then registers its result.
// A commit sweeps the ring twice, one cell a cycle while a held output does not stall it: 2n+2 results.
// One item is worked at a time; the next is taken once the last result is registered.
// Reset (i_rst_n low, synchronous) clears open operations, entry count and output,
// and restores log_start 2, log_size 31; the block table is left as it is.

module write_ahead_log_manager (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wal_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [wal_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // [1:0] operation, [21:2] block_number, [23:22] zero
    input  logic [wal_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [2:0] status, [4:3] command, [24:5] source_block, [44:25] dest_block,
    // [49:45] entry_count, [50] pin_new, [51] wake_waiters, [55:52] zero
    output logic [wal_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    output logic                            o_m_tlast
);
    import wal_pkg::*;

    logic [START_W-1:0]    r_log_start;
    logic [SIZE_W-1:0]     r_log_size;
    logic                  r_out_valid;
    t_result               r_out;

    logic                  w_can_load;
    logic                  w_res_valid;
    t_result               w_res;
    t_chain_ctl            w_chain;
    logic [BLOCK_BITS-1:0] w_head;
    logic                  w_match;
    logic [BLOCK_BITS-1:0] w_key;
    logic [BLOCK_BITS-1:0] w_in_blk;

    assign w_in_blk   = BLOCK_BITS'(i_s_tdata[21:2]);
    assign w_can_load = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log_start <= START_W'(2);
            r_log_size  <= SIZE_W'(31);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'({1'b0, i_cfg_addr}))
                CFG_LOG_START: r_log_start <= i_cfg_data[START_W-1:0];
                CFG_LOG_SIZE:  r_log_size  <= i_cfg_data[SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Key for search and load is the block held by the controller's latch
    wal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_tvalid),
        .o_in_ready  (o_s_tready),
        .i_op        (t_op'(i_s_tdata[1:0])),
        .i_blk       (w_in_blk),
        .i_log_start (r_log_start),
        .i_log_size  (r_log_size),
        .i_can_load  (w_can_load),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_chain     (w_chain),
        .o_key       (w_key),
        .i_head      (w_head),
        .i_match     (w_match)
    );

    wal_chain u_chain (
        .i_clk   (i_clk),
        .i_ctl   (w_chain),
        .i_key   (w_key),
        .o_head  (w_head),
        .o_match (w_match)
    );

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_can_load) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_can_load && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {{OUT_PAD_W{1'b0}}, r_out.wake_waiters, r_out.pin_new,
                         r_out.entry_count, r_out.dest_block, r_out.source_block,
                         r_out.command, r_out.status};

endmodule
